@@ sv/btnc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket tag checker package
// Shared types, character codes, result codes and the known tag name table.
// ----------------------------------------------------------------------------
`default_nettype none

package btnc_pkg;

  localparam int unsigned NUM_KNOWN = 12;
  localparam int unsigned NAME_MAX  = 5;
  localparam int unsigned MAX_RUN   = 16;

  localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
  localparam logic [11:0] ALL_NAMES = 12'hFFF;
  localparam logic [2:0]  LEN_SAT   = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;

  localparam logic [2:0] ERR_EMPTY_BRACKETS = 3'd0;
  localparam logic [2:0] ERR_EMPTY_NAME     = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN        = 3'd2;
  localparam logic [2:0] ERR_CLOSE_NO_OPEN  = 3'd3;
  localparam logic [2:0] ERR_MISMATCH       = 3'd4;
  localparam logic [2:0] ERR_UNCLOSED       = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW       = 3'd6;

  localparam logic SEV_ERROR   = 1'b0;
  localparam logic SEV_WARNING = 1'b1;

  localparam logic [3:0] ID_NONE        = 4'd0;
  localparam logic [3:0] ID_NOT_STACKED = 4'd10;

  localparam logic [2:0] KNOWN_LEN [NUM_KNOWN] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd2, 3'd2, 3'd2, 3'd5, 3'd4, 3'd5, 3'd3
  };

  localparam logic [7:0] KNOWN_TEXT [NUM_KNOWN][NAME_MAX] = '{
    '{"b", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"u", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "d", "e", 8'h00},
    '{"h", "1", 8'h00, 8'h00, 8'h00},
    '{"h", "2", 8'h00, 8'h00, 8'h00},
    '{"h", "3", 8'h00, 8'h00, 8'h00},
    '{"q", "u", "o", "t", "e"},
    '{"l", "i", "s", "t", 8'h00},
    '{"t", "a", "b", "l", "e"},
    '{"i", "m", "g", 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [11:0] mask;
    logic [2:0]  len;
  } name_t;

  typedef struct packed {
    logic [2:0]  err_code;
    logic        severity;
    logic [19:0] line_number;
    logic [15:0] column;
    logic [3:0]  tag_id;
    logic [19:0] opened_line;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic accept;
    logic close_eval;
    logic drain_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_close;
    logic drain_start;
    logic res_empty;
    logic res_free;
    logic drain_last;
  } dp_status_t;

  function automatic name_t name_feed(input logic [11:0] mask, input logic [2:0] len,
                                      input logic [7:0] c);
    name_t r;
    r.mask = mask;
    r.len  = len;
    if (len >= LEN_SAT) begin
      r.mask = '0;
    end else begin
      for (int k = 0; k < NUM_KNOWN; k++) begin
        if (KNOWN_LEN[k] <= len) begin
          r.mask[k] = 1'b0;
        end else if (KNOWN_TEXT[k][len] != c) begin
          r.mask[k] = 1'b0;
        end
      end
      r.len = len + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [3:0] name_id(input logic [11:0] mask, input logic [2:0] len);
    logic [3:0] id;
    id = ID_NONE;
    for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
      if (mask[k] && (KNOWN_LEN[k] == len)) begin
        id = 4'(k + 1);
      end
    end
    return id;
  endfunction

endpackage

`default_nettype wire

@@ sv/btnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bracket tag checker controller
// Sequences byte acceptance, the closing tag stack compare and the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module btnc_ctrl
  import btnc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_CLOSE_RD = 2'd1;
  localparam logic [1:0] ST_DRAIN_RD = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d          = state_q;
    in_stall_o       = 1'b1;
    cmd_o.accept     = 1'b0;
    cmd_o.close_eval = 1'b0;
    cmd_o.drain_emit = 1'b0;
    unique case (state_q)
      ST_ACCEPT: begin
        in_stall_o   = !status_i.res_empty;
        cmd_o.accept = in_valid_i && status_i.res_empty;
        if (cmd_o.accept && status_i.pop_close) begin
          state_d = ST_CLOSE_RD;
        end else if (cmd_o.accept && status_i.drain_start) begin
          state_d = ST_DRAIN_RD;
        end
      end
      ST_CLOSE_RD: begin
        cmd_o.close_eval = 1'b1;
        state_d          = ST_ACCEPT;
      end
      ST_DRAIN_RD: begin
        cmd_o.drain_emit = status_i.res_free;
        if (status_i.res_free && status_i.drain_last) begin
          state_d = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/btnc_datapath.sv @@
// ----------------------------------------------------------------------------
// Bracket tag checker datapath
// Scanner registers, name matching, tag stack memory and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module btnc_datapath
  import btnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  input  ctrl_cmd_t   ctrl_cmd_i,
  output dp_status_t  status_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output res_t        out_o
);

  localparam int unsigned CW  = (COLUMN_BITS < 16) ? COLUMN_BITS : 16;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned EW  = 4 + 20 + CW;
  localparam logic [CW-1:0] COL_MAX = {CW{1'b1}};

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_AFTER = 3'd1;
  localparam logic [2:0] MODE_OPEN  = 3'd2;
  localparam logic [2:0] MODE_CLOSE = 3'd3;
  localparam logic [2:0] MODE_SKIP  = 3'd4;

  logic [2:0]     mode_q, mode_d;
  logic [19:0]    line_q, line_d;
  logic [CW-1:0]  col_q, col_d;
  logic [11:0]    mask_q, mask_d;
  logic [2:0]     len_q, len_d;
  logic           ended_q, ended_d;
  logic [CW-1:0]  bcol_q, bcol_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [3:0]     cnt_q, cnt_d;

  logic [EW-1:0]  stack_mem [STACK_DEPTH];
  logic [EW-1:0]  rd_q;
  logic [SPW-1:0] sp_dec;
  logic           push, pop_rd;
  logic [EW-1:0]  push_entry;

  logic           res_valid_q, res_ld;
  res_t           res_q, res_d;
  logic           out_valid_q, out_free;
  res_t           out_q;

  logic [CW-1:0]  col_inc;
  name_t          fed, fresh;
  logic [3:0]     cur_id;
  logic [3:0]     rd_id;
  logic [19:0]    rd_line;
  logic [CW-1:0]  rd_col;
  logic           is_text, drain_last;

  assign sp_dec   = sp_q - SPW'(1);
  assign col_inc  = (col_q != COL_MAX) ? col_q + CW'(1) : col_q;
  assign fed      = name_feed(mask_q, len_q, char_code_i);
  assign fresh    = name_feed(ALL_NAMES, 3'd0, char_code_i);
  assign cur_id   = name_id(mask_q, len_q);
  assign rd_id    = rd_q[EW-1 -: 4];
  assign rd_line  = rd_q[CW +: 20];
  assign rd_col   = rd_q[CW-1:0];
  assign is_text  = !cmd_i && (char_code_i != CH_NL) && (char_code_i != CH_NUL);
  assign drain_last = (sp_q == '0) || (cnt_q == 4'(MAX_RUN - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign push_entry = {cur_id, line_q, bcol_q};

  assign status_o.pop_close   = is_text && (mode_q == MODE_CLOSE) && (char_code_i == CH_RBR)
                                && (sp_q != '0);
  assign status_o.drain_start = cmd_i && (sp_q != '0);
  assign status_o.res_empty   = !res_valid_q;
  assign status_o.res_free    = !res_valid_q || out_free;
  assign status_o.drain_last  = drain_last;

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    mask_d  = mask_q;
    len_d   = len_q;
    ended_d = ended_q;
    bcol_d  = bcol_q;
    sp_d    = sp_q;
    cnt_d   = cnt_q;
    push    = 1'b0;
    pop_rd  = 1'b0;
    res_ld  = 1'b0;
    res_d   = '0;
    res_d.line_number = line_q;
    res_d.column      = 16'(bcol_q);
    res_d.last_of_run = 1'b1;

    if (ctrl_cmd_i.accept) begin
      if (cmd_i) begin
        mode_d  = MODE_IDLE;
        line_d  = 20'd1;
        col_d   = '0;
        bcol_d  = '0;
        mask_d  = ALL_NAMES;
        len_d   = 3'd0;
        ended_d = 1'b0;
        cnt_d   = 4'd0;
        pop_rd  = (sp_q != '0);
      end else if (char_code_i == CH_NL) begin
        mode_d = MODE_IDLE;
        if (line_q != LINE_MAX) begin
          line_d = line_q + 20'd1;
        end
        col_d = '0;
      end else begin
        col_d = col_inc;
        if (char_code_i == CH_NUL) begin
          mode_d = MODE_SKIP;
        end else begin
          case (mode_q)
            MODE_IDLE: begin
              if (char_code_i == CH_LBR) begin
                bcol_d = col_inc;
                mode_d = MODE_AFTER;
              end
            end
            MODE_AFTER: begin
              if (char_code_i == CH_RBR) begin
                res_ld         = 1'b1;
                res_d.err_code = ERR_EMPTY_BRACKETS;
                res_d.severity = SEV_WARNING;
                mode_d         = MODE_IDLE;
              end else if (char_code_i == CH_SLASH) begin
                mask_d  = ALL_NAMES;
                len_d   = 3'd0;
                ended_d = 1'b0;
                mode_d  = MODE_CLOSE;
              end else begin
                mode_d = MODE_OPEN;
                if (char_code_i == CH_SPACE) begin
                  mask_d  = ALL_NAMES;
                  len_d   = 3'd0;
                  ended_d = 1'b1;
                end else begin
                  mask_d  = fresh.mask;
                  len_d   = fresh.len;
                  ended_d = 1'b0;
                end
              end
            end
            MODE_OPEN: begin
              if (char_code_i == CH_RBR) begin
                mode_d = MODE_IDLE;
                if (len_q == 3'd0) begin
                  res_ld         = 1'b1;
                  res_d.err_code = ERR_EMPTY_NAME;
                  res_d.severity = SEV_ERROR;
                end else if (cur_id == ID_NONE) begin
                  res_ld         = 1'b1;
                  res_d.err_code = ERR_UNKNOWN;
                  res_d.severity = SEV_WARNING;
                end else if (cur_id < ID_NOT_STACKED) begin
                  if (sp_q < SPW'(STACK_DEPTH)) begin
                    push = 1'b1;
                    sp_d = sp_q + SPW'(1);
                  end else begin
                    res_ld         = 1'b1;
                    res_d.err_code = ERR_OVERFLOW;
                    res_d.severity = SEV_ERROR;
                    res_d.tag_id   = cur_id;
                  end
                end
              end else if (!ended_q) begin
                if (char_code_i == CH_SPACE) begin
                  ended_d = 1'b1;
                end else begin
                  mask_d = fed.mask;
                  len_d  = fed.len;
                end
              end
            end
            MODE_CLOSE: begin
              if (char_code_i == CH_RBR) begin
                mode_d = MODE_IDLE;
                if (sp_q == '0) begin
                  res_ld         = 1'b1;
                  res_d.err_code = ERR_CLOSE_NO_OPEN;
                  res_d.severity = SEV_ERROR;
                  res_d.tag_id   = cur_id;
                end else begin
                  pop_rd = 1'b1;
                end
              end else begin
                mask_d = fed.mask;
                len_d  = fed.len;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (ctrl_cmd_i.close_eval && (rd_id != cur_id)) begin
      res_ld            = 1'b1;
      res_d.err_code    = ERR_MISMATCH;
      res_d.severity    = SEV_ERROR;
      res_d.tag_id      = rd_id;
      res_d.opened_line = rd_line;
    end

    if (ctrl_cmd_i.drain_emit) begin
      res_ld            = 1'b1;
      res_d.err_code    = ERR_UNCLOSED;
      res_d.severity    = SEV_ERROR;
      res_d.line_number = rd_line;
      res_d.column      = 16'(rd_col);
      res_d.tag_id      = rd_id;
      res_d.last_of_run = drain_last;
      if (!drain_last) begin
        pop_rd = 1'b1;
        cnt_d  = cnt_q + 4'd1;
      end
    end

    if (pop_rd) begin
      sp_d = sp_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= 20'd1;
      col_q   <= '0;
      mask_q  <= ALL_NAMES;
      len_q   <= 3'd0;
      ended_q <= 1'b0;
      bcol_q  <= '0;
      sp_q    <= '0;
      cnt_q   <= 4'd0;
    end else begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      ended_q <= ended_d;
      bcol_q  <= bcol_d;
      sp_q    <= sp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[sp_q[AW-1:0]] <= push_entry;
    end
    if (pop_rd) begin
      rd_q <= stack_mem[sp_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_ld) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && out_free) begin
        res_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= res_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      res_q <= res_d;
    end
    if (out_free && res_valid_q) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ sv/bracket_tag_nesting_checker.sv @@
// ----------------------------------------------------------------------------
// Bracket tag nesting checker
// Takes one byte per cycle while not stalled; the input stalls while a report
// waits in the result register, while a popped closing tag is compared against
// its stack entry, and during the drain. A report passes the result register
// and then the output register. End of input reports each unclosed tag (at most
// sixteen per request) and reports nothing on an empty stack.
// Asynchronous reset clears the scanner and empties the stack by its pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_tag_nesting_checker
  import btnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  err_code_o,
  output logic        severity_o,
  output logic [19:0] line_number_o,
  output logic [15:0] column_o,
  output logic [3:0]  tag_id_o,
  output logic [19:0] opened_line_o,
  output logic        last_of_run_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  res_t       out_res;

  btnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  btnc_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .ctrl_cmd_i  (ctrl_cmd),
    .status_o    (dp_status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign err_code_o    = out_res.err_code;
  assign severity_o    = out_res.severity;
  assign line_number_o = out_res.line_number;
  assign column_o      = out_res.column;
  assign tag_id_o      = out_res.tag_id;
  assign opened_line_o = out_res.opened_line;
  assign last_of_run_o = out_res.last_of_run;

endmodule

`default_nettype wire
